@@ rtl/usd_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
package usd_pkg;

  localparam int CP_W        = 21;
  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int HELD_DEPTH  = 3;
  localparam int QUEUE_DEPTH = HELD_DEPTH + 1;
  localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int HELD_CNT_W  = $clog2(HELD_DEPTH + 1);

  // result queue depth, a power of two
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_VAL   = 8'hC0;
  localparam logic [7:0] LEAD2_BITS  = 8'h1F;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_VAL   = 8'hE0;
  localparam logic [7:0] LEAD3_BITS  = 8'h0F;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_VAL   = 8'hF0;
  localparam logic [7:0] LEAD4_BITS  = 8'h07;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_VAL    = 8'h80;
  localparam logic [7:0] CONT_BITS   = 8'h3F;
  localparam logic [CP_W-1:0] REPL_CP = CP_W'(8'h3F);

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_replacement;
    logic            last_of_run;
    logic            text_done;
  } usd_result_t;

  typedef struct packed {
    usd_result_t [MAX_RESULTS-1:0] res;
    logic [RES_CNT_W-1:0]          count;
  } usd_batch_t;

endpackage

@@ rtl/usd_in_if.sv @@
// Byte input channel: valid/ready with one raw byte and an end-of-text mark.
interface usd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

@@ rtl/usd_out_if.sv @@
// Code point output channel: valid/ready with one decoded result.
interface usd_out_if import usd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            is_replacement;
  logic            last_of_run;
  logic            text_done;

  modport source (output valid, output code_point, output is_replacement,
                  output last_of_run, output text_done, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input last_of_run, input text_done, output ready);
endinterface

@@ rtl/usd_decode.sv @@
// Held-byte state and single-pass decode of the byte queue into a result batch.
module usd_decode import usd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] stage_byte,
  input  logic       stage_eot,
  output usd_batch_t batch
);

  logic [7:0]            held_bytes [HELD_DEPTH];
  logic [7:0]            held_bytes_next [HELD_DEPTH];
  logic [HELD_CNT_W-1:0] held_count;
  logic [HELD_CNT_W-1:0] held_count_next;

  logic [7:0]            q [QUEUE_DEPTH];
  logic [Q_CNT_W-1:0]    n;
  logic [Q_CNT_W-1:0]    pos;
  logic [Q_CNT_W-1:0]    avail;
  logic [Q_CNT_W-1:0]    len;
  logic [Q_CNT_W-1:0]    rem;
  logic [Q_IDX_W-1:0]    cidx;
  logic                  stop;
  logic                  ok;
  logic                  lead_ok;
  logic [7:0]            b;
  logic [7:0]            c;
  logic [CP_W-1:0]       cp;
  logic [RES_CNT_W-1:0]  cnt;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) q[i] = 8'h00;
    for (int i = 0; i < HELD_DEPTH; i++) begin
      if (HELD_CNT_W'(i) < held_count) q[i] = held_bytes[i];
    end
    q[held_count] = stage_byte;
    n = Q_CNT_W'(held_count) + Q_CNT_W'(1);

    pos     = '0;
    stop    = 1'b0;
    cnt     = '0;
    b       = 8'h00;
    c       = 8'h00;
    cp      = '0;
    len     = '0;
    avail   = '0;
    ok      = 1'b1;
    lead_ok = 1'b0;
    cidx    = '0;
    batch   = '0;

    // each pass consumes at least one byte or stops
    for (int it = 0; it < QUEUE_DEPTH; it++) begin
      if (!stop && pos < n) begin
        b       = q[pos[Q_IDX_W-1:0]];
        avail   = n - pos;
        lead_ok = 1'b1;
        ok      = 1'b1;
        if (b < ASCII_LIMIT) begin
          batch.res[cnt[RES_IDX_W-1:0]].code_point = CP_W'(b);
          cnt     = cnt + RES_CNT_W'(1);
          pos     = pos + Q_CNT_W'(1);
          lead_ok = 1'b0;
        end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
          cp  = CP_W'(b & LEAD2_BITS);
          len = Q_CNT_W'(2);
        end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
          cp  = CP_W'(b & LEAD3_BITS);
          len = Q_CNT_W'(3);
        end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
          cp  = CP_W'(b & LEAD4_BITS);
          len = Q_CNT_W'(4);
        end else begin
          // stray continuation or F8-FF
          batch.res[cnt[RES_IDX_W-1:0]].code_point     = REPL_CP;
          batch.res[cnt[RES_IDX_W-1:0]].is_replacement = 1'b1;
          cnt     = cnt + RES_CNT_W'(1);
          pos     = pos + Q_CNT_W'(1);
          lead_ok = 1'b0;
        end

        if (lead_ok) begin
          if (avail < len) begin
            // incomplete: hold, or flush as one replacement at end of text
            if (stage_eot) begin
              batch.res[cnt[RES_IDX_W-1:0]].code_point     = REPL_CP;
              batch.res[cnt[RES_IDX_W-1:0]].is_replacement = 1'b1;
              cnt = cnt + RES_CNT_W'(1);
              pos = n;
            end
            stop = 1'b1;
          end else begin
            for (int j = 1; j < QUEUE_DEPTH; j++) begin
              if (Q_CNT_W'(j) < len) begin
                cidx = pos[Q_IDX_W-1:0] + Q_IDX_W'(j);
                c    = q[cidx];
                if ((c & CONT_MASK) != CONT_VAL) ok = 1'b0;
                cp = {cp[CP_W-7:0], c[5:0]};
              end
            end
            if (ok) begin
              batch.res[cnt[RES_IDX_W-1:0]].code_point = cp;
              pos = pos + len;
            end else begin
              batch.res[cnt[RES_IDX_W-1:0]].code_point     = REPL_CP;
              batch.res[cnt[RES_IDX_W-1:0]].is_replacement = 1'b1;
              pos = pos + Q_CNT_W'(1);
            end
            cnt = cnt + RES_CNT_W'(1);
          end
        end
      end
    end

    if (cnt != '0) begin
      batch.res[RES_IDX_W'(cnt - RES_CNT_W'(1))].last_of_run = 1'b1;
      batch.res[RES_IDX_W'(cnt - RES_CNT_W'(1))].text_done   = stage_eot;
    end
    batch.count = cnt;

    rem = n - pos;
    for (int i = 0; i < HELD_DEPTH; i++) begin
      held_bytes_next[i] = held_bytes[i];
      if (Q_CNT_W'(i) < rem) held_bytes_next[i] = q[pos[Q_IDX_W-1:0] + Q_IDX_W'(i)];
    end
    held_count_next = stage_eot ? '0 : HELD_CNT_W'(rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (go) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < HELD_DEPTH; i++) held_bytes[i] <= held_bytes_next[i];
    end
  end

endmodule

@@ rtl/usd_result_fifo.sv @@
// Result queue: takes a batch of up to four results per cycle, drains one per cycle while ready.
module usd_result_fifo import usd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  usd_batch_t batch,
  output logic       room,
  usd_out_if.source  points
);

  usd_result_t           mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic [FIFO_CNT_W-1:0] count_next;
  logic [RES_CNT_W-1:0]  push_cnt;
  logic                  pop;

  assign push_cnt = push ? batch.count : '0;
  assign pop      = points.valid && points.ready;
  assign room     = count <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS);

  assign count_next = count + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);

  assign points.valid          = count != '0;
  assign points.code_point     = mem[rd_ptr].code_point;
  assign points.is_replacement = mem[rd_ptr].is_replacement;
  assign points.last_of_run    = mem[rd_ptr].last_of_run;
  assign points.text_done      = mem[rd_ptr].text_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_cnt);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (RES_CNT_W'(k) < push_cnt) mem[wr_ptr + FIFO_PTR_W'(k)] <= batch.res[k];
    end
  end

endmodule

@@ rtl/utf8_stream_decoder_core.sv @@
// Top level of the UTF-8 stream decoder: input register, decode, result queue.
//
// Takes one byte of UTF-8 text per cycle on the text channel and returns code
// points on the points channel. A byte enters an input register, from which
// it is decoded together with up to three bytes still held from an
// incomplete sequence; the zero to four results it causes go into an 8-entry
// result queue in that same cycle, so a byte passes through the input
// register and the result queue before its first result reaches the points
// channel. Sustained rate is one byte per cycle as long as each byte gives at
// most one result and the points channel is always ready; the points channel
// drains one result per cycle while it is ready. The input
// stalls only when the result queue has fewer than four free entries. The
// last result of each byte carries last_of_run, and the last result of a
// byte marked end_of_text also carries text_done; such a byte flushes any
// unfinished sequence as a single '?' and clears the held bytes. A byte that
// only extends a pending sequence gives no result. No checks for overlong
// forms, surrogates or the code point range are made.
module utf8_stream_decoder_core import usd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  usd_in_if.sink    text,
  usd_out_if.source points
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_eot;
  logic       go;
  logic       room;
  logic       take;
  usd_batch_t batch;

  // advance the staged byte into decode only when a full batch fits
  assign go         = stage_valid && room;
  assign text.ready = !stage_valid || go;
  assign take       = text.valid && text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (go) begin
      stage_valid <= 1'b0;
    end
  end

  // hold payload until the next transaction
  always_ff @(posedge clk) begin
    if (take) begin
      stage_byte <= text.in_byte;
      stage_eot  <= text.end_of_text;
    end
  end

  usd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .stage_byte (stage_byte),
    .stage_eot  (stage_eot),
    .batch      (batch)
  );

  usd_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (go),
    .batch  (batch),
    .room   (room),
    .points (points)
  );

endmodule
